FILE: hdl/adcrb_pkg.sv
// Shared constants and types of the converter register block.
package adcrb_pkg;

   localparam int NUM_CHANNELS_DEFAULT = 7;

   localparam int DATA_W   = 32;
   localparam int OFFSET_W = 9;
   localparam int CHAN_W   = 3;
   localparam int IRQ_W    = 28;
   localparam int SAMPLE_W = 10;

   // Access kinds.
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Global registers, offset bits 7:0.
   localparam logic [7:0] G_IRQ_MASKED = 8'h00;
   localparam logic [7:0] G_IRQ_STATUS = 8'h04;
   localparam logic [7:0] G_IRQ_ENABLE = 8'h08;
   localparam logic [7:0] G_SPARE0     = 8'h0C;
   localparam logic [7:0] G_SPARE1     = 8'h10;
   localparam logic [7:0] G_SPARE2     = 8'h14;

   // Channel registers, offset bits 4:0.
   localparam logic [4:0] C_COMMAND = 5'h00;
   localparam logic [4:0] C_MISC    = 5'h04;
   localparam logic [4:0] C_COUNT   = 5'h08;
   localparam logic [4:0] C_ADDR    = 5'h0C;
   localparam logic [4:0] C_SAMPLE  = 5'h10;
   localparam logic [4:0] C_RATE    = 5'h14;

   // Configuration register indexes.
   localparam logic CFG_SENSING_DISABLED = 1'b0;
   localparam logic CFG_KEYPAD_KIND      = 1'b1;

   localparam logic [SAMPLE_W-1:0] FULL_SCALE   = 10'h3FF;
   localparam logic [SAMPLE_W-1:0] NORMAL_LEVEL = 10'd930;
   localparam logic [SAMPLE_W-1:0] KEYPAD_BASE  = 10'd10;
   localparam logic [SAMPLE_W-1:0] KEYPAD_STEP  = 10'd21;
   localparam logic [CHAN_W-1:0]   KEYPAD_CHAN  = 3'd3;

   typedef struct packed {
      logic [27:0]         misc;
      logic [24:0]         count;
      logic [29:0]         addr;
      logic [SAMPLE_W-1:0] sample;
      logic [SAMPLE_W-1:0] rate;
   } chan_entry_type;

   localparam int ENTRY_W = $bits(chan_entry_type);

endpackage

FILE: hdl/adcrb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module adcrb_ram #(
   parameter int Width = 8,
   parameter int Depth = 8,
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/adc_register_block.sv
// A request is registered together with its channel RAM read; its execute step then loads the response register.
// A new request is not taken until the execute step of the last one is done, as the channel RAM read is registered.
// A waiting response lets one more request transfer; its execute step then waits for the response.
// Reset clears interrupt status, enable, configuration and the channel valid bits;
// a channel whose valid bit is clear reads as all zeros, so no clearing pass is needed.
module adc_register_block #(
   parameter int NUM_CHANNELS = adcrb_pkg::NUM_CHANNELS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // reg_offset[8:0], write_data[40:9], zero pad
   input  logic        req_tuser,  // opcode[0]
   // Response stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // read_data[31:0], irq_level[32], zero pad
   output logic        rsp_tuser,  // bad_access[0]
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   import adcrb_pkg::*;

   localparam int ChanAddrW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                 state_ff, state_in;
   logic                 op_ff;
   logic [OFFSET_W-1:0]  offset_ff;
   logic [DATA_W-1:0]    wdata_ff;
   logic [IRQ_W-1:0]     status_ff, status_in;
   logic [IRQ_W-1:0]     enable_ff, enable_in;
   logic                 sensing_disabled_ff;
   logic [1:0]           keypad_kind_ff;
   logic [NUM_CHANNELS-1:0] chan_valid_ff;

   logic                 rsp_valid_ff;
   logic [DATA_W-1:0]    rsp_rdata_ff, rsp_rdata_in;
   logic                 rsp_bad_ff, rsp_bad_in;
   logic                 rsp_irq_ff, rsp_irq_in;

   logic                 req_xfer;
   logic                 exec_fire;
   logic                 cfg_write;
   logic [CHAN_W-1:0]    req_chan;
   logic [CHAN_W-1:0]    chan;
   logic [ChanAddrW-1:0] chan_idx;
   logic                 is_chan;
   logic                 chan_ok;
   logic                 ram_we;
   logic [ENTRY_W-1:0]   ram_rdata;
   chan_entry_type       entry_cur, entry_in;
   logic [SAMPLE_W-1:0]  sample_val;

   assign req_chan  = req_tdata[7:5];
   assign chan      = offset_ff[7:5];
   assign chan_idx  = chan[ChanAddrW-1:0];
   assign is_chan   = offset_ff[8];
   assign chan_ok   = chan < CHAN_W'(NUM_CHANNELS);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign exec_fire  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   adcrb_ram #(
      .Width (ENTRY_W),
      .Depth (NUM_CHANNELS)
   ) u_chan_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (chan_idx),
      .wr_data (entry_in),
      .rd_en   (req_xfer),
      .rd_addr (req_chan[ChanAddrW-1:0]),
      .rd_data (ram_rdata)
   );

   // An entry that was never written reads as zero, as its channel valid bit is still clear.
   always_comb begin
      if (chan_ok && chan_valid_ff[chan_idx]) begin
         entry_cur = chan_entry_type'(ram_rdata);
      end else begin
         entry_cur = '0;
      end
   end

   always_comb begin
      if (sensing_disabled_ff) begin
         sample_val = FULL_SCALE;
      end else if (chan == KEYPAD_CHAN) begin
         sample_val = KEYPAD_BASE + KEYPAD_STEP * {8'b0, keypad_kind_ff};
      end else begin
         sample_val = NORMAL_LEVEL;
      end
   end

   // Decode and read-modify-write of one access.
   always_comb begin
      rsp_rdata_in = '0;
      rsp_bad_in   = 1'b0;
      status_in    = status_ff;
      enable_in    = enable_ff;
      entry_in     = entry_cur;
      ram_we       = 1'b0;
      if (!is_chan) begin
         if (op_ff == OP_READ) begin
            case (offset_ff[7:0])
               G_IRQ_MASKED: rsp_rdata_in = DATA_W'(status_ff & enable_ff);
               G_IRQ_STATUS: rsp_rdata_in = DATA_W'(status_ff);
               G_IRQ_ENABLE: rsp_rdata_in = DATA_W'(enable_ff);
               default:      rsp_bad_in   = 1'b1;
            endcase
         end else begin
            case (offset_ff[7:0])
               G_IRQ_STATUS: status_in = status_ff & ~wdata_ff[IRQ_W-1:0];
               G_IRQ_ENABLE: enable_in = wdata_ff[IRQ_W-1:0];
               G_SPARE0, G_SPARE1, G_SPARE2: ;
               default:      rsp_bad_in = 1'b1;
            endcase
         end
      end else if (!chan_ok) begin
         rsp_bad_in = 1'b1;
      end else if (op_ff == OP_READ) begin
         case (offset_ff[4:0])
            C_COMMAND: rsp_rdata_in = '0;
            C_MISC:    rsp_rdata_in = DATA_W'(entry_cur.misc);
            C_COUNT:   rsp_rdata_in = DATA_W'(entry_cur.count);
            C_ADDR:    rsp_rdata_in = {entry_cur.addr, 2'b00};
            C_SAMPLE:  rsp_rdata_in = DATA_W'(entry_cur.sample);
            C_RATE:    rsp_rdata_in = DATA_W'(entry_cur.rate);
            default:   rsp_bad_in   = 1'b1;
         endcase
      end else begin
         ram_we = 1'b1;
         case (offset_ff[4:0])
            C_COMMAND: begin
               entry_in.sample = sample_val;
               status_in = status_ff | (IRQ_W'(3) << {chan, 2'b00});
            end
            C_MISC:  entry_in.misc  = wdata_ff[27:0];
            C_COUNT: entry_in.count = wdata_ff[24:0];
            C_ADDR:  entry_in.addr  = wdata_ff[31:2];
            C_RATE:  entry_in.rate  = wdata_ff[SAMPLE_W-1:0];
            default: begin
               rsp_bad_in = 1'b1;
               ram_we     = 1'b0;
            end
         endcase
      end
      ram_we     = ram_we && exec_fire;
      rsp_irq_in = |(status_in & enable_in);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_IDLE;
         status_ff           <= '0;
         enable_ff           <= '0;
         chan_valid_ff       <= '0;
         rsp_valid_ff        <= 1'b0;
         sensing_disabled_ff <= 1'b0;
         keypad_kind_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (exec_fire) begin
            status_ff    <= status_in;
            enable_ff    <= enable_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ram_we) begin
            chan_valid_ff[chan_idx] <= 1'b1;
         end
         if (cfg_write) begin
            case (csr_paddr[2])
               CFG_SENSING_DISABLED: sensing_disabled_ff <= csr_pwdata[0];
               CFG_KEYPAD_KIND:      keypad_kind_ff      <= csr_pwdata[1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff     <= req_tuser;
         offset_ff <= req_tdata[8:0];
         wdata_ff  <= req_tdata[40:9];
      end
      if (exec_fire) begin
         rsp_rdata_ff <= rsp_rdata_in;
         rsp_bad_ff   <= rsp_bad_in;
         rsp_irq_ff   <= rsp_irq_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_irq_ff, rsp_rdata_ff};
   assign rsp_tuser  = rsp_bad_ff;

   always_comb begin
      case (csr_paddr[2])
         CFG_SENSING_DISABLED: csr_prdata = {31'b0, sensing_disabled_ff};
         CFG_KEYPAD_KIND:      csr_prdata = {30'b0, keypad_kind_ff};
         default:              csr_prdata = '0;
      endcase
   end
   assign csr_pready = 1'b1;

   // A bad access never returns data.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[31:0] == '0)
      else $error("bad access returned nonzero data");

   // Interrupt state changes only when a result is loaded, so a pending result
   // always shows the current interrupt level.
   a_irq_current: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[32] == |(status_ff & enable_ff))
      else $error("pending interrupt level is stale");

   // A request transfer is followed by the execute step that uses the RAM data.
   a_exec_follows: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == ST_EXEC)
      else $error("execute step missing after request transfer");

   // The channel RAM is written only by a completing channel write.
   a_ram_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> exec_fire && is_chan && op_ff == OP_WRITE && !rsp_bad_in)
      else $error("unexpected channel RAM write");

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the converter register block: bus accesses against a local register map.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import adcrb_pkg::*;

   localparam int NUM_CH          = NUM_CHANNELS_DEFAULT;
   localparam int PERIOD          = 12;
   localparam int RESET_CYCLES    = 12;
   localparam int ITEMS_PER_PHASE = 208;
   localparam int HOLD_OFF_AT     = 300;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int STALL_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 8;
   localparam bit TYPED           = 1'b1;
   localparam bit PREDICT         = 1'b0;

   localparam logic [4:0] CHAN_REGS [6] = '{C_COMMAND, C_MISC, C_COUNT, C_ADDR, C_SAMPLE, C_RATE};
   localparam logic [7:0] GLOB_REGS [6] =
      '{G_IRQ_MASKED, G_IRQ_STATUS, G_IRQ_ENABLE, G_SPARE0, G_SPARE1, G_SPARE2};
   localparam logic       PHASE_SENS [6] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
   localparam logic [1:0] PHASE_KIND [6] = '{2'd3, 2'd3, 2'd1, 2'd2, 2'd0, 2'd0};

   typedef struct packed {
      logic [31:0] rd;
      logic        bad;
      logic        irq;
   } reply_type;

   typedef struct {
      logic        op;
      logic [8:0]  off;
      logic [31:0] data;
      bit          typed;
      reply_type   want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;  // reg_offset[8:0], write_data[40:9], zero pad
   logic        req_tuser = 1'b0;  // opcode[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;  // read_data[31:0], irq_level[32], zero pad
   logic        rsp_tuser;  // bad_access[0]
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   adc_register_block dut (.*);

   always #(PERIOD / 2) clock = ~clock;

   // Local copy of the register map.
   logic [27:0] irq_status_q = '0;
   logic [27:0] irq_enable_q = '0;
   logic [27:0] misc_q   [NUM_CH] = '{default: '0};
   logic [24:0] count_q  [NUM_CH] = '{default: '0};
   logic [29:0] addr_q   [NUM_CH] = '{default: '0};
   logic [9:0]  sample_q [NUM_CH] = '{default: '0};
   logic [9:0]  rate_q   [NUM_CH] = '{default: '0};
   logic        sensing_off = 1'b0;
   logic [1:0]  keypad_code = '0;

   reply_type    pending_replies[$];
   plan_row_type plan[$];
   int        mismatches = 0;
   int        replies_checked = 0;
   int        bad_replies = 0;
   int        irq_replies = 0;
   int        accepted_requests = 0;
   bit        send_calm = 1'b0;
   bit        recv_calm = 1'b0;

   // Applies one access to the local register map and returns the reply it must produce.
   function automatic reply_type register_access(input logic op, input logic [8:0] off,
                                                 input logic [31:0] wdata);
      reply_type  r;
      logic [2:0] ch;
      int         bit_lo;
      r.rd  = '0;
      r.bad = 1'b0;
      ch = off[7:5];
      bit_lo = 4 * int'(ch);
      if (!off[8]) begin
         if (op == OP_READ) begin
            case (off[7:0])
               G_IRQ_MASKED: r.rd = {4'b0, irq_status_q & irq_enable_q};
               G_IRQ_STATUS: r.rd = {4'b0, irq_status_q};
               G_IRQ_ENABLE: r.rd = {4'b0, irq_enable_q};
               default: r.bad = 1'b1;
            endcase
         end else begin
            case (off[7:0])
               G_IRQ_STATUS: irq_status_q &= ~wdata[27:0];
               G_IRQ_ENABLE: irq_enable_q = wdata[27:0];
               G_SPARE0, G_SPARE1, G_SPARE2: ;
               default: r.bad = 1'b1;
            endcase
         end
      end else if (int'(ch) >= NUM_CH) begin
         r.bad = 1'b1;
      end else if (op == OP_READ) begin
         case (off[4:0])
            C_COMMAND: r.rd = '0;
            C_MISC:    r.rd = {4'b0, misc_q[ch]};
            C_COUNT:   r.rd = {7'b0, count_q[ch]};
            C_ADDR:    r.rd = {addr_q[ch], 2'b00};
            C_SAMPLE:  r.rd = {22'b0, sample_q[ch]};
            C_RATE:    r.rd = {22'b0, rate_q[ch]};
            default:   r.bad = 1'b1;
         endcase
      end else begin
         case (off[4:0])
            C_COMMAND: begin
               // A conversion is taken whatever the data word holds.
               if (sensing_off)
                  sample_q[ch] = FULL_SCALE;
               else if (ch == KEYPAD_CHAN)
                  sample_q[ch] = KEYPAD_BASE + KEYPAD_STEP * {8'b0, keypad_code};
               else
                  sample_q[ch] = NORMAL_LEVEL;
               irq_status_q[bit_lo +: 2] = 2'b11;
            end
            C_MISC:  misc_q[ch] = wdata[27:0];
            C_COUNT: count_q[ch] = wdata[24:0];
            C_ADDR:  addr_q[ch] = wdata[31:2];
            C_RATE:  rate_q[ch] = wdata[9:0];
            default: r.bad = 1'b1;
         endcase
      end
      r.irq = |(irq_status_q & irq_enable_q);
      return r;
   endfunction

   function automatic logic [8:0] chan_off(input int ch, input logic [4:0] creg);
      return {1'b1, 3'(ch), creg};
   endfunction

   function automatic void add_row(input logic op, input logic [8:0] off, input logic [31:0] data,
                                   input bit typed, input logic [31:0] rd, input logic bad,
                                   input logic irq);
      plan_row_type row;
      row.op    = op;
      row.off   = off;
      row.data  = data;
      row.typed = typed;
      row.want  = '{rd: rd, bad: bad, irq: irq};
      plan.push_back(row);
   endfunction

   // Offers one request and returns at the edge where it is transferred.
   task automatic send_request(input logic op, input logic [8:0] off, input logic [31:0] data);
      int gap;
      if ($urandom_range(0, 39) == 0)
         send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'b0, data, off};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      accepted_requests++;
   endtask

   task automatic write_setting(input logic idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (idx == CFG_SENSING_DISABLED)
         sensing_off = value[0];
      else
         keypad_code = value[1:0];
   endtask

   task automatic wait_idle();
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      logic        op;
      logic [8:0]  off;
      logic [31:0] data;
      reply_type   reply;
      int          pick;

      // Reset values, the decode holes and the extremes of each channel field.
      add_row(OP_READ,  {1'b0, G_IRQ_MASKED}, '0, TYPED, '0, 1'b0, 1'b0);
      add_row(OP_READ,  {1'b0, G_IRQ_STATUS}, '0, TYPED, '0, 1'b0, 1'b0);
      add_row(OP_READ,  {1'b0, G_IRQ_ENABLE}, '0, TYPED, '0, 1'b0, 1'b0);
      add_row(OP_WRITE, {1'b0, G_IRQ_MASKED}, '1, TYPED, '0, 1'b1, 1'b0);
      add_row(OP_READ,  {1'b0, G_SPARE0}, '0, TYPED, '0, 1'b1, 1'b0);
      add_row(OP_WRITE, {1'b0, G_SPARE0}, '1, TYPED, '0, 1'b0, 1'b0);
      add_row(OP_WRITE, {1'b0, G_SPARE1}, '1, TYPED, '0, 1'b0, 1'b0);
      add_row(OP_WRITE, {1'b0, G_IRQ_ENABLE}, '1, TYPED, '0, 1'b0, 1'b0);
      add_row(OP_WRITE, chan_off(0, C_COMMAND), 32'hDEADBEEF, TYPED, '0, 1'b0, 1'b1);
      add_row(OP_READ,  chan_off(0, C_SAMPLE), '0, TYPED, 32'd930, 1'b0, 1'b1);
      add_row(OP_WRITE, chan_off(3, C_COMMAND), '0, PREDICT, '0, 1'b0, 1'b0);
      add_row(OP_READ,  chan_off(3, C_SAMPLE), '0, TYPED, 32'd10, 1'b0, 1'b1);
      add_row(OP_WRITE, chan_off(6, C_MISC), '1, PREDICT, '0, 1'b0, 1'b0);
      add_row(OP_READ,  chan_off(6, C_MISC), '0, TYPED, 32'h0FFF_FFFF, 1'b0, 1'b1);
      add_row(OP_WRITE, chan_off(6, C_COUNT), '1, PREDICT, '0, 1'b0, 1'b0);
      add_row(OP_READ,  chan_off(6, C_COUNT), '0, TYPED, 32'h01FF_FFFF, 1'b0, 1'b1);
      add_row(OP_WRITE, chan_off(6, C_ADDR), '1, PREDICT, '0, 1'b0, 1'b0);
      add_row(OP_READ,  chan_off(6, C_ADDR), '0, TYPED, 32'hFFFF_FFFC, 1'b0, 1'b1);
      add_row(OP_WRITE, chan_off(6, C_RATE), '1, PREDICT, '0, 1'b0, 1'b0);
      add_row(OP_READ,  chan_off(6, C_RATE), '0, TYPED, 32'h0000_03FF, 1'b0, 1'b1);
      add_row(OP_WRITE, chan_off(6, C_SAMPLE), '1, TYPED, '0, 1'b1, 1'b1);
      add_row(OP_READ,  chan_off(7, C_COMMAND), '0, TYPED, '0, 1'b1, 1'b1);
      add_row(OP_READ,  9'h101, '0, TYPED, '0, 1'b1, 1'b1);
      add_row(OP_READ,  {1'b0, G_IRQ_STATUS}, '0, PREDICT, '0, 1'b0, 1'b0);
      add_row(OP_WRITE, {1'b0, G_IRQ_STATUS}, '1, TYPED, '0, 1'b0, 1'b0);
      add_row(OP_READ,  9'h0FF, '0, TYPED, '0, 1'b1, 1'b0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         send_request(plan[i].op, plan[i].off, plan[i].data);
         reply = register_access(plan[i].op, plan[i].off, plan[i].data);
         pending_replies.push_back(plan[i].typed ? plan[i].want : reply);
      end

      for (int ph = 0; ph < 6; ph++) begin
         req_tvalid <= 1'b0;
         wait_idle();
         // Bits above each field are random; the block must ignore them.
         write_setting(CFG_SENSING_DISABLED, ($urandom & ~32'h1) | {31'b0, PHASE_SENS[ph]});
         write_setting(CFG_KEYPAD_KIND, ($urandom & ~32'h3) | {30'b0, PHASE_KIND[ph]});
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            op   = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
               0: data = '0;
               1: data = '1;
               default: data = $urandom;
            endcase
            if (pick < 60)
               off = chan_off($urandom_range(0, NUM_CH - 1), CHAN_REGS[$urandom_range(0, 5)]);
            else if (pick < 82)
               off = {1'b0, GLOB_REGS[$urandom_range(0, 5)]};
            else if (pick < 87)
               off = chan_off(7, 5'($urandom));
            else
               off = 9'($urandom);
            send_request(op, off, data);
            pending_replies.push_back(register_access(op, off, data));
         end
      end

      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d replies to %0d accesses under 7 converter settings.",
               replies_checked, accepted_requests);
      $display("%0d replies flagged a bad access, %0d carried a raised interrupt.",
               bad_replies, irq_replies);
      if (mismatches == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   // Response side: random stalls, plus one long hold-off that backs the block up.
   initial begin
      int        stall;
      reply_type want;
      while (reset) @(posedge clock);
      forever begin
         if (replies_checked == HOLD_OFF_AT) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         if ($urandom_range(0, 39) == 0)
            recv_calm = !recv_calm;
         stall = recv_calm ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         replies_checked++;
         if (rsp_tuser)
            bad_replies++;
         if (rsp_tdata[32])
            irq_replies++;
         if (pending_replies.size() == 0) begin
            $error("unexpected reply transfer: read_data %h bad_access %b irq_level %b",
                   rsp_tdata[31:0], rsp_tuser, rsp_tdata[32]);
            mismatches++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_tdata[31:0] !== want.rd) begin
               $error("read_data: expected %h, got %h", want.rd, rsp_tdata[31:0]);
               mismatches++;
            end
            if (rsp_tuser !== want.bad) begin
               $error("bad_access: expected %b, got %b", want.bad, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata[32] !== want.irq) begin
               $error("irq_level: expected %b, got %b", want.irq, rsp_tdata[32]);
               mismatches++;
            end
         end
      end
   end

   // Ends the run if no transfer of any kind happens for too long.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles, %0d replies outstanding.",
                  STALL_LIMIT, pending_replies.size());
         $display("tb_top NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
